// ===== rtl/core/ttsu_pkg.sv =====
package ttsu_pkg;

	localparam int unsigned FAST_W      = 16;
	localparam int unsigned SLOW_W      = 32;
	localparam int unsigned RATE_W      = 20;
	localparam int unsigned PRESCALE_W  = 32;
	localparam int unsigned CFG_IDX_W   = 8;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned USEC_SHIFT_DEF = 12;

	localparam logic [RATE_W-1:0] USEC_PER_SEC = RATE_W'(1000000);

	localparam logic [PRESCALE_W-1:0] PRESCALE_RST = PRESCALE_W'(1);
	localparam logic [RATE_W-1:0]     RATE_RST     = RATE_W'(100);

	localparam logic [CFG_IDX_W-1:0] REG_USEC_PRESCALE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_TICK_RATE = CFG_IDX_W'(1);

	typedef struct packed {
		logic [RATE_W-1:0] rem;
		logic [SLOW_W-1:0] quo;
		logic [RATE_W-1:0] srem;
		logic [RATE_W-1:0] squo;
		logic [31:0]       usec;
	} ttsu_div_t;

endpackage

// ===== rtl/core/ttsu_snap_if.sv =====
interface ttsu_snap_if import ttsu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FAST_W-1:0] fast_count_before;
	logic [SLOW_W-1:0] slow_count;
	logic [FAST_W-1:0] fast_count_after;

	modport source (output valid, fast_count_before, slow_count, fast_count_after,
		input ready);
	modport sink (input valid, fast_count_before, slow_count, fast_count_after,
		output ready);
endinterface

// ===== rtl/core/ttsu_time_if.sv =====
interface ttsu_time_if;
	logic        valid;
	logic        ready;
	logic [31:0] seconds;
	logic [31:0] microseconds;

	modport source (output valid, seconds, microseconds, input ready);
	modport sink (input valid, seconds, microseconds, output ready);
endinterface

// ===== rtl/core/ttsu_cfg_if.sv =====
interface ttsu_cfg_if import ttsu_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ttsu_div_stage.sv =====
module ttsu_div_stage import ttsu_pkg::*; #(
	parameter bit DO_STEP = 1'b1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [RATE_W-1:0] rate,
	input  logic              in_valid,
	input  ttsu_div_t         in_data,
	output logic              out_valid,
	output ttsu_div_t         out_data
);

	logic [RATE_W:0]   trial;
	logic              qbit;
	logic [RATE_W:0]   strial;
	logic              sbit;
	ttsu_div_t         nxt;

	always_comb begin
		nxt   = in_data;
		trial = {in_data.rem, in_data.quo[SLOW_W-1]};
		qbit  = (trial >= {1'b0, rate});
		nxt.rem = qbit ? RATE_W'(trial - {1'b0, rate}) : trial[RATE_W-1:0];
		nxt.quo = {in_data.quo[SLOW_W-2:0], qbit};
		strial = {in_data.srem, in_data.squo[RATE_W-1]};
		sbit   = (strial >= {1'b0, rate});
		if (DO_STEP) begin
			nxt.srem = sbit ? RATE_W'(strial - {1'b0, rate}) : strial[RATE_W-1:0];
			nxt.squo = {in_data.squo[RATE_W-2:0], sbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

// ===== rtl/core/timer_ticks_to_sec_usec.sv =====
// An accepted snapshot beat passes the input register, the divider stages and the
// output stages to its result beat. Throughput: one snapshot per cycle; the input
// register, the 32 restoring divider stages and the two multiply-add stages all
// advance together whenever the result register is free. Reset: arst_n clears all
// valid bits and sets usec_prescale to 1 and slow_tick_rate to 100.
module timer_ticks_to_sec_usec import ttsu_pkg::*; #(
	parameter int unsigned USEC_SHIFT = USEC_SHIFT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ttsu_snap_if.sink   snap,
	ttsu_time_if.source res,
	ttsu_cfg_if.sink    cfg
);

	localparam int unsigned NSTG = SLOW_W;

	logic [PRESCALE_W-1:0] prescale_q;
	logic [RATE_W-1:0]     rate_q;
	logic [RATE_W-1:0]     rate_eff;
	logic                  en;

	logic                  valid_s1;
	ttsu_div_t             data_s1;
	logic [SLOW_W-1:0]     slow_fix;
	logic [31:0]           prod_fast;

	logic                  div_valid_s [0:NSTG];
	ttsu_div_t             div_data_s  [0:NSTG];

	logic                  valid_s2;
	logic [31:0]           sec_s2;
	logic [31:0]           usec_s2;
	logic [31:0]           remprod_s2;
	logic [2*RATE_W-1:0]   remprod;

	logic                  valid_s3;
	logic [31:0]           sec_s3;
	logic [31:0]           usec_s3;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= PRESCALE_RST;
			rate_q     <= RATE_RST;
		end else if (cfg.valid) begin
			if (cfg.index == REG_USEC_PRESCALE) begin
				prescale_q <= cfg.data;
			end else if (cfg.index == REG_SLOW_TICK_RATE) begin
				rate_q <= cfg.data[RATE_W-1:0];
			end
		end
	end

	assign rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;

	assign en         = !valid_s3 || res.ready;
	assign snap.ready = en;

	always_comb begin
		slow_fix  = snap.slow_count + SLOW_W'(snap.fast_count_after < snap.fast_count_before);
		prod_fast = 32'({16'b0, snap.fast_count_after} * prescale_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= snap.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.rem  <= '0;
			data_s1.quo  <= slow_fix;
			data_s1.srem <= '0;
			data_s1.squo <= USEC_PER_SEC;
			data_s1.usec <= prod_fast >> USEC_SHIFT;
		end
	end

	assign div_valid_s[0] = valid_s1;
	assign div_data_s[0]  = data_s1;

	for (genvar k = 0; k < NSTG; k++) begin : g_div
		ttsu_div_stage #(
			.DO_STEP (k < RATE_W)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.rate      (rate_eff),
			.in_valid  (div_valid_s[k]),
			.in_data   (div_data_s[k]),
			.out_valid (div_valid_s[k+1]),
			.out_data  (div_data_s[k+1])
		);
	end

	assign remprod = div_data_s[NSTG].rem * div_data_s[NSTG].squo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= div_valid_s[NSTG];
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s2     <= div_data_s[NSTG].quo;
			usec_s2    <= div_data_s[NSTG].usec;
			remprod_s2 <= remprod[31:0];
			sec_s3     <= sec_s2;
			usec_s3    <= usec_s2 + remprod_s2;
		end
	end

	assign res.valid        = valid_s3;
	assign res.seconds      = sec_s3;
	assign res.microseconds = usec_s3;

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import ttsu_pkg::*;

	typedef struct packed {
		logic [FAST_W-1:0] fast_before;
		logic [SLOW_W-1:0] slow;
		logic [FAST_W-1:0] fast_after;
	} snapshot_t;

	typedef struct packed {
		logic [31:0] seconds;
		logic [31:0] microseconds;
	} time_t;

	logic clk;
	logic arst_n;

	ttsu_snap_if snap ();
	ttsu_time_if res ();
	ttsu_cfg_if cfg ();

	timer_ticks_to_sec_usec DUT (
		.clk(clk),
		.arst_n(arst_n),
		.snap(snap.sink),
		.res(res.source),
		.cfg(cfg.sink)
	);

	logic [31:0] prescale_model;
	logic [31:0] rate_model;

	snapshot_t pending_snaps[$];
	time_t expected_times[$];
	int errors;
	int cycles;
	bit in_pause;
	int in_gap;
	int out_gap;
	int hold_len;
	bit hold_req;
	bit cfg_busy;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic time_t convert_snapshot(snapshot_t s);
		logic [31:0] slow;
		logic [31:0] rate;
		logic [31:0] prod;
		logic [31:0] rem;
		logic [31:0] step;
		time_t t;
		slow = s.slow;
		rate = (rate_model == 0) ? 32'd1 : rate_model;
		if (s.fast_after < s.fast_before) begin
			slow = slow + 32'd1;
		end
		prod = {16'd0, s.fast_after} * prescale_model;
		t.seconds = slow / rate;
		rem = slow % rate;
		step = 32'd1000000 / rate;
		t.microseconds = (prod >> USEC_SHIFT_DEF) + rem * step;
		return t;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap.valid <= 1'b0;
			snap.fast_count_before <= '0;
			snap.slow_count <= '0;
			snap.fast_count_after <= '0;
			in_gap <= 0;
		end else begin
			if (snap.valid && snap.ready) begin
				expected_times.push_back(convert_snapshot(
					{snap.fast_count_before, snap.slow_count, snap.fast_count_after}));
			end
			if (!snap.valid || snap.ready) begin
				if (in_gap > 0 || in_pause || pending_snaps.size() == 0) begin
					snap.valid <= 1'b0;
					if (in_gap > 0) in_gap <= in_gap - 1;
				end else begin
					snapshot_t s;
					s = pending_snaps.pop_front();
					snap.valid <= 1'b1;
					snap.fast_count_before <= s.fast_before;
					snap.slow_count <= s.slow;
					snap.fast_count_after <= s.fast_after;
					in_gap <= ($urandom_range(0, 9) < 6) ? 0 :
						(($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
							: $urandom_range(1, 3));
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			out_gap <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_times.size() == 0) begin
					report("unexpected beat", res.seconds, '0);
				end else begin
					time_t w;
					w = expected_times.pop_front();
					if (res.seconds !== w.seconds) report("seconds", res.seconds, w.seconds);
					if (res.microseconds !== w.microseconds)
						report("microseconds", res.microseconds, w.microseconds);
				end
			end
			if (hold_req) begin
				res.ready <= 1'b0;
				out_gap <= hold_len;
			end else if (out_gap > 0) begin
				res.ready <= 1'b0;
				out_gap <= out_gap - 1;
			end else if ($urandom_range(0, 9) < 7) begin
				res.ready <= 1'b1;
			end else begin
				res.ready <= 1'b0;
				out_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 3);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("** timer_ticks_to_sec_usec: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_USEC_PRESCALE) prescale_model = value;
		else if (idx == REG_SLOW_TICK_RATE) rate_model = value & 32'hFFFFF;
	endtask

	task automatic drain();
		while (pending_snaps.size() != 0 || snap.valid || expected_times.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic snapshot_t random_snap();
		snapshot_t s;
		s.fast_before = $urandom;
		s.fast_after = $urandom;
		case ($urandom_range(0, 5))
			0: s.slow = 32'hFFFFFFFF;
			1: s.slow = $urandom_range(0, 2000);
			default: s.slow = $urandom;
		endcase
		if ($urandom_range(0, 7) == 0) s.fast_after = s.fast_before;
		return s;
	endfunction

	task automatic run_phase(logic [31:0] prescale, logic [31:0] rate, int count);
		write_reg(REG_USEC_PRESCALE, prescale);
		write_reg(REG_SLOW_TICK_RATE, rate);
		repeat (count) pending_snaps.push_back(random_snap());
		drain();
	endtask

	initial begin
		in_pause = 0;
		hold_req = 0;
		hold_len = 0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		prescale_model = 32'd1;
		rate_model = 32'd100;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		pending_snaps.push_back({16'h0000, 32'h00000000, 16'h0000});
		pending_snaps.push_back({16'hFFFF, 32'hFFFFFFFF, 16'hFFFF});
		pending_snaps.push_back({16'h0001, 32'hFFFFFFFF, 16'h0000});
		pending_snaps.push_back({16'hFFFF, 32'h00000063, 16'h0000});
		pending_snaps.push_back({16'h0000, 32'h00000064, 16'hFFFF});
		pending_snaps.push_back({16'h8000, 32'hAAAAAAAA, 16'h7FFF});
		drain();

		write_reg(8'd7, 32'h12345678);
		run_phase(32'hFFFFFFFF, 32'd1000000, 12);
		run_phase(32'h000FFFFF, 32'd0, 8);
		run_phase(32'd0, 32'hFFFFF, 8);
		run_phase(32'd4096, 32'd1, 8);

		write_reg(REG_USEC_PRESCALE, 32'd3355443);
		write_reg(REG_SLOW_TICK_RATE, 32'd100);
		in_pause = 1;
		repeat (200) pending_snaps.push_back(random_snap());
		@(posedge clk);
		hold_len <= 150;
		hold_req <= 1'b1;
		in_pause = 0;
		@(posedge clk);
		hold_req <= 1'b0;
		drain();

		for (int p = 0; p < 10; p++) begin
			run_phase($urandom, (p % 3 == 0) ? $urandom_range(1, 1000) : $urandom_range(1, 1000000),
				160);
		end

		if (errors == 0) begin
			$display("** timer_ticks_to_sec_usec: PASSED **");
		end else begin
			$display("** timer_ticks_to_sec_usec: FAILED **");
		end
		$finish;
	end
endmodule
